// File: sv/osd_pkg.sv
// Package with the shared word types, operation and status codes for the schedule decoder.
`default_nettype none
package osd_pkg;

    localparam int DEF_MAX_JOBS     = 64;
    localparam int DEF_MAX_MACHINES = 32;

    localparam logic [1:0] OP_LOAD_JOB     = 2'd0;
    localparam logic [1:0] OP_LOAD_MACHINE = 2'd1;
    localparam logic [1:0] OP_GENE         = 2'd2;
    localparam logic [1:0] OP_CLEAR        = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_OPS    = 2'd1;
    localparam logic [1:0] STATUS_SATURATED = 2'd2;

    localparam logic [62:0] SUM_MAX = {63{1'b1}};

    typedef struct packed {
        logic [1:0]  op;
        logic [5:0]  job_index;
        logic [4:0]  machine_index;
        logic [31:0] time_value;
        logic [15:0] processing_time;
        logic [15:0] job_weight;
        logic [7:0]  op_count;
    } osd_in_t;

    typedef struct packed {
        logic [31:0] start_time;
        logic [31:0] end_time;
        logic        job_done;
        logic [31:0] makespan;
        logic [62:0] weighted_flow_sum;
        logic [1:0]  status;
    } osd_out_t;

    typedef struct packed {
        logic [31:0] ready;
        logic [31:0] release_time;
        logic [15:0] weight;
        logic [7:0]  ops_left;
    } osd_job_entry_t;

    typedef struct packed {
        logic        valid;
        logic        clear;
        logic        done;
        logic [1:0]  status;
        logic [31:0] start_time;
        logic [31:0] end_time;
        logic [31:0] release_time;
        logic [15:0] weight;
    } osd_token_t;

endpackage
`default_nettype wire

// File: sv/osd_store.sv
// Job and machine tables held in two synchronous memories with registered read data.
`default_nettype none
module osd_store #(
    parameter int MAX_JOBS     = osd_pkg::DEF_MAX_JOBS,
    parameter int MAX_MACHINES = osd_pkg::DEF_MAX_MACHINES,
    parameter int JAW          = 6,
    parameter int MAW          = 5
) (
    input  wire logic                    clk,
    input  wire logic                    job_rd_en,
    input  wire logic [JAW-1:0]          job_rd_addr,
    output osd_pkg::osd_job_entry_t      job_rd_data,
    input  wire logic                    job_wr_en,
    input  wire logic [JAW-1:0]          job_wr_addr,
    input  wire osd_pkg::osd_job_entry_t job_wr_data,
    input  wire logic                    mach_rd_en,
    input  wire logic [MAW-1:0]          mach_rd_addr,
    output logic [31:0]                  mach_rd_data,
    input  wire logic                    mach_wr_en,
    input  wire logic [MAW-1:0]          mach_wr_addr,
    input  wire logic [31:0]             mach_wr_data
);
    import osd_pkg::*;

    osd_job_entry_t job_mem [MAX_JOBS];
    logic [31:0]    mach_mem [MAX_MACHINES];
    osd_job_entry_t job_rd_reg;
    logic [31:0]    mach_rd_reg;

    always_ff @(posedge clk)
    begin
        if (job_wr_en)
        begin
            job_mem[job_wr_addr] <= job_wr_data;
        end
        if (job_rd_en)
        begin
            job_rd_reg <= job_mem[job_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mach_wr_en)
        begin
            mach_mem[mach_wr_addr] <= mach_wr_data;
        end
        if (mach_rd_en)
        begin
            mach_rd_reg <= mach_mem[mach_rd_addr];
        end
    end

    assign job_rd_data  = job_rd_reg;
    assign mach_rd_data = mach_rd_reg;

endmodule
`default_nettype wire

// File: sv/osd_accum.sv
// Pipeline that forms weighted flow, keeps makespan and flow sum, and drives the result word.
`default_nettype none
module osd_accum (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire osd_pkg::osd_token_t token,
    output logic                     result_valid,
    output osd_pkg::osd_out_t        result
);
    import osd_pkg::*;

    logic        a_valid_reg;
    logic        b_valid_reg;
    logic        c_valid_reg;
    osd_token_t  a_reg;
    osd_token_t  b_reg;
    osd_token_t  c_reg;
    logic [31:0] b_flow_reg;
    logic [47:0] c_prod_reg;
    logic [31:0] makespan_reg;
    logic [31:0] makespan_next;
    logic [62:0] sum_reg;
    logic [62:0] sum_next;
    logic        res_valid_reg;
    osd_out_t    res_reg;
    osd_out_t    res_next;
    logic [31:0] flow;
    logic [63:0] sum_wide;

    always_comb
    begin
        flow = (a_reg.end_time >= a_reg.release_time) ?
               (a_reg.end_time - a_reg.release_time) : 32'd0;
    end

    always_comb
    begin
        sum_wide      = {1'b0, sum_reg} + {16'd0, c_prod_reg};
        makespan_next = makespan_reg;
        sum_next      = sum_reg;
        res_next.status = c_reg.status;
        if (c_reg.done)
        begin
            if (c_reg.end_time > makespan_reg)
            begin
                makespan_next = c_reg.end_time;
            end
            if (sum_wide[63])
            begin
                sum_next        = SUM_MAX;
                res_next.status = STATUS_SATURATED;
            end
            else
            begin
                sum_next = sum_wide[62:0];
            end
        end
        res_next.start_time        = c_reg.start_time;
        res_next.end_time          = c_reg.end_time;
        res_next.job_done          = c_reg.done;
        res_next.makespan          = makespan_next;
        res_next.weighted_flow_sum = sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            makespan_reg  <= 32'd0;
            sum_reg       <= 63'd0;
        end
        else
        begin
            a_valid_reg   <= token.valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            res_valid_reg <= c_valid_reg && !c_reg.clear;
            if (c_valid_reg)
            begin
                if (c_reg.clear)
                begin
                    makespan_reg <= 32'd0;
                    sum_reg      <= 63'd0;
                end
                else
                begin
                    makespan_reg <= makespan_next;
                    sum_reg      <= sum_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= token;
        b_reg      <= a_reg;
        b_flow_reg <= flow;
        c_reg      <= b_reg;
        c_prod_reg <= 48'(b_flow_reg) * 48'(b_reg.weight);
        res_reg    <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule
`default_nettype wire

// File: sv/operation_sequence_schedule_decoder.sv
// Top level of the schedule decoder: command decode, table read-modify-write and result pipeline.
//
//  Channel   Ports                   Handshake
//  command   start, busy, cmd        word taken when start is high and busy is low
//  result    result_valid, result    word present for one cycle, always taken
//
// Load and clear words leave busy low. A gene word raises busy: the tables are
// read in the accept cycle and written back in the next, while busy is high, on the
// single write port of each memory. Its result then passes stages A, B, C and the result register.
// Reset clears the control state and the totals; the tables hold nothing until loaded.
// The result side has no stall, so the accumulation pipeline never holds.
`default_nettype none
module operation_sequence_schedule_decoder #(
    parameter int MAX_JOBS     = osd_pkg::DEF_MAX_JOBS,
    parameter int MAX_MACHINES = osd_pkg::DEF_MAX_MACHINES
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire osd_pkg::osd_in_t cmd,
    output logic                  result_valid,
    output osd_pkg::osd_out_t     result
);
    import osd_pkg::*;

    localparam int JAW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int MAW = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;

    typedef enum logic {S_IDLE, S_CALC} state_t;

    state_t         state_reg;
    logic           accept;
    logic [31:0]    jx_ext;
    logic [31:0]    mx_ext;
    logic           job_in_range;
    logic           mach_in_range;
    logic           gene_go;
    logic [JAW-1:0] jaddr;
    logic [MAW-1:0] maddr;
    logic [JAW-1:0] jaddr_reg;
    logic [MAW-1:0] maddr_reg;
    logic [15:0]    pt_reg;

    osd_job_entry_t job_rd_data;
    logic [31:0]    mach_rd_data;
    logic           job_wr_en;
    logic [JAW-1:0] job_wr_addr;
    osd_job_entry_t job_wr_data;
    logic           mach_wr_en;
    logic [MAW-1:0] mach_wr_addr;
    logic [31:0]    mach_wr_data;

    logic [31:0]    start_t;
    logic [32:0]    end_wide;
    logic [31:0]    end_t;
    logic [7:0]     ops_next;
    logic           calc_write;
    osd_token_t     token;

    assign accept        = start && !busy;
    assign jx_ext        = 32'(cmd.job_index);
    assign mx_ext        = 32'(cmd.machine_index);
    assign job_in_range  = jx_ext < 32'(MAX_JOBS);
    assign mach_in_range = mx_ext < 32'(MAX_MACHINES);
    assign jaddr         = jx_ext[JAW-1:0];
    assign maddr         = mx_ext[MAW-1:0];
    assign gene_go       = accept && (cmd.op == OP_GENE) && job_in_range && mach_in_range;
    assign busy          = (state_reg == S_CALC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (gene_go)
                    begin
                        state_reg <= S_CALC;
                    end
                end
                S_CALC:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (gene_go)
        begin
            jaddr_reg <= jaddr;
            maddr_reg <= maddr;
            pt_reg    <= cmd.processing_time;
        end
    end

    always_comb
    begin
        start_t    = (job_rd_data.ready > mach_rd_data) ? job_rd_data.ready : mach_rd_data;
        end_wide   = {1'b0, start_t} + {17'd0, pt_reg};
        end_t      = end_wide[32] ? 32'hFFFF_FFFF : end_wide[31:0];
        ops_next   = job_rd_data.ops_left - 8'd1;
        calc_write = busy && (job_rd_data.ops_left != 8'd0);

        token = '0;
        if (busy)
        begin
            token.valid        = 1'b1;
            token.release_time = job_rd_data.release_time;
            token.weight       = job_rd_data.weight;
            if (job_rd_data.ops_left == 8'd0)
            begin
                token.status = STATUS_NO_OPS;
            end
            else
            begin
                token.start_time = start_t;
                token.end_time   = end_t;
                token.done       = (ops_next == 8'd0);
                token.status     = end_wide[32] ? STATUS_SATURATED : STATUS_OK;
            end
        end
        else if (accept && (cmd.op == OP_CLEAR))
        begin
            token.valid = 1'b1;
            token.clear = 1'b1;
        end

        if (calc_write)
        begin
            job_wr_en                = 1'b1;
            job_wr_addr              = jaddr_reg;
            job_wr_data.ready        = end_t;
            job_wr_data.release_time = job_rd_data.release_time;
            job_wr_data.weight       = job_rd_data.weight;
            job_wr_data.ops_left     = ops_next;
            mach_wr_en               = 1'b1;
            mach_wr_addr             = maddr_reg;
            mach_wr_data             = end_t;
        end
        else
        begin
            job_wr_en                = accept && (cmd.op == OP_LOAD_JOB) && job_in_range;
            job_wr_addr              = jaddr;
            job_wr_data.ready        = cmd.time_value;
            job_wr_data.release_time = cmd.time_value;
            job_wr_data.weight       = cmd.job_weight;
            job_wr_data.ops_left     = cmd.op_count;
            mach_wr_en               = accept && (cmd.op == OP_LOAD_MACHINE) && mach_in_range;
            mach_wr_addr             = maddr;
            mach_wr_data             = cmd.time_value;
        end
    end

    osd_store #(
        .MAX_JOBS     (MAX_JOBS),
        .MAX_MACHINES (MAX_MACHINES),
        .JAW          (JAW),
        .MAW          (MAW)
    ) u_store (
        .clk          (clk),
        .job_rd_en    (gene_go),
        .job_rd_addr  (jaddr),
        .job_rd_data  (job_rd_data),
        .job_wr_en    (job_wr_en),
        .job_wr_addr  (job_wr_addr),
        .job_wr_data  (job_wr_data),
        .mach_rd_en   (gene_go),
        .mach_rd_addr (maddr),
        .mach_rd_data (mach_rd_data),
        .mach_wr_en   (mach_wr_en),
        .mach_wr_addr (mach_wr_addr),
        .mach_wr_data (mach_wr_data)
    );

    osd_accum u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .token        (token),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the operation sequence schedule decoder.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import osd_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;

    class schedule_scoreboard;
        bit [31:0] ready_at[64];
        bit [31:0] release_at[64];
        bit [15:0] weight_of[64];
        bit [7:0]  ops_left[64];
        bit [31:0] machine_free[32];
        bit [31:0] makespan;
        bit [62:0] flow_sum;
        osd_out_t  expected_q[$];
        int        errors;

        function void note_command(osd_in_t w);
            osd_out_t  r;
            bit [32:0] raw_end;
            bit [63:0] weighted;
            bit [63:0] total;
            case (w.op)
                OP_LOAD_JOB:
                begin
                    release_at[w.job_index] = w.time_value;
                    ready_at[w.job_index] = w.time_value;
                    weight_of[w.job_index] = w.job_weight;
                    ops_left[w.job_index] = w.op_count;
                end
                OP_LOAD_MACHINE: machine_free[w.machine_index] = w.time_value;
                OP_CLEAR:
                begin
                    makespan = '0;
                    flow_sum = '0;
                end
                OP_GENE:
                begin
                    r = '0;
                    r.status = STATUS_OK;
                    if (ops_left[w.job_index] == 8'd0)
                    begin
                        r.status = STATUS_NO_OPS;
                    end
                    else
                    begin
                        r.start_time = (ready_at[w.job_index] > machine_free[w.machine_index])
                            ? ready_at[w.job_index] : machine_free[w.machine_index];
                        raw_end = {1'b0, r.start_time} + 33'(w.processing_time);
                        if (raw_end[32])
                        begin
                            r.end_time = '1;
                            r.status = STATUS_SATURATED;
                        end
                        else
                        begin
                            r.end_time = raw_end[31:0];
                        end
                        ready_at[w.job_index] = r.end_time;
                        machine_free[w.machine_index] = r.end_time;
                        ops_left[w.job_index] = ops_left[w.job_index] - 8'd1;
                        if (ops_left[w.job_index] == 8'd0)
                        begin
                            r.job_done = 1'b1;
                            if (r.end_time > makespan)
                                makespan = r.end_time;
                            weighted = '0;
                            if (r.end_time >= release_at[w.job_index])
                                weighted = 64'(r.end_time - release_at[w.job_index])
                                    * 64'(weight_of[w.job_index]);
                            total = 64'(flow_sum) + weighted;
                            if (total > 64'(SUM_MAX))
                            begin
                                flow_sum = SUM_MAX;
                                r.status = STATUS_SATURATED;
                            end
                            else
                            begin
                                flow_sum = total[62:0];
                            end
                        end
                    end
                    r.makespan = makespan;
                    r.weighted_flow_sum = flow_sum;
                    expected_q.push_back(r);
                end
                default: ;
            endcase
        endfunction

        function void compare(string name, logic [62:0] want, logic [62:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(osd_out_t got);
            osd_out_t want;
            if (expected_q.size() == 0)
            begin
                $error("result word with nothing expected: %h", got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare("start_time", 63'(want.start_time), 63'(got.start_time));
            compare("end_time", 63'(want.end_time), 63'(got.end_time));
            compare("job_done", 63'(want.job_done), 63'(got.job_done));
            compare("makespan", 63'(want.makespan), 63'(got.makespan));
            compare("weighted_flow_sum", want.weighted_flow_sum, got.weighted_flow_sum);
            compare("status", 63'(want.status), 63'(got.status));
        endfunction
    endclass

    logic     clk = 1'b0;
    logic     rst_n;
    logic     start;
    logic     busy;
    osd_in_t  cmd;
    logic     result_valid;
    osd_out_t result;

    schedule_scoreboard placements = new();

    bit job_loaded[64];
    bit machine_loaded[32];
    int ops_pending[64];
    bit idling_on;
    int idle_cycles;

    operation_sequence_schedule_decoder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (result_valid === 1'b1)
                placements.check_result(result);
            if (start === 1'b1 && busy === 1'b0)
                placements.note_command(cmd);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) || result_valid === 1'b1)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    function automatic osd_in_t random_word();
        osd_in_t w;
        w.op = 2'($urandom_range(0, 3));
        w.job_index = 6'($urandom);
        w.machine_index = 5'($urandom);
        w.time_value = $urandom;
        w.processing_time = 16'($urandom);
        w.job_weight = 16'($urandom);
        w.op_count = 8'($urandom);
        return w;
    endfunction

    function automatic bit [31:0] random_time();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return 32'($urandom_range(0, 5000));
        if (pick < 90)
            return $urandom;
        return 32'hFFFF_FFFF - 32'($urandom_range(0, 200000));
    endfunction

    function automatic bit [7:0] random_count();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return 8'd0;
        if (pick < 20)
            return 8'($urandom);
        return 8'($urandom_range(1, 8));
    endfunction

    function automatic int pick_job(bit any_loaded);
        int j;
        int k;
        j = $urandom_range(0, 63);
        if (!any_loaded)
        begin
            for (k = 0; k < 64; k++)
                if (ops_pending[(j + k) % 64] > 0)
                    return (j + k) % 64;
        end
        while (!job_loaded[j])
            j = $urandom_range(0, 63);
        return j;
    endfunction

    function automatic int pick_machine();
        int m;
        m = $urandom_range(0, 31);
        while (!machine_loaded[m])
            m = $urandom_range(0, 31);
        return m;
    endfunction

    task automatic send_word(osd_in_t w);
        int gap;
        gap = 0;
        if (idling_on && $urandom_range(0, 99) < 8)
            gap = $urandom_range(1, 5);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= w;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    task automatic send_load_job(int j, bit [31:0] t, bit [15:0] wt, bit [7:0] cnt);
        osd_in_t w;
        w = random_word();
        w.op = OP_LOAD_JOB;
        w.job_index = 6'(j);
        w.time_value = t;
        w.job_weight = wt;
        w.op_count = cnt;
        job_loaded[j] = 1'b1;
        ops_pending[j] = int'(cnt);
        send_word(w);
    endtask

    task automatic send_load_machine(int m, bit [31:0] t);
        osd_in_t w;
        w = random_word();
        w.op = OP_LOAD_MACHINE;
        w.machine_index = 5'(m);
        w.time_value = t;
        machine_loaded[m] = 1'b1;
        send_word(w);
    endtask

    task automatic send_clear();
        osd_in_t w;
        w = random_word();
        w.op = OP_CLEAR;
        send_word(w);
    endtask

    task automatic send_gene(int j, int m, bit [15:0] pt);
        osd_in_t w;
        w = random_word();
        w.op = OP_GENE;
        w.job_index = 6'(j);
        w.machine_index = 5'(m);
        w.processing_time = pt;
        if (ops_pending[j] > 0)
            ops_pending[j]--;
        send_word(w);
    endtask

    initial
    begin
        int pick;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        idling_on = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_load_machine(0, 32'd0);
        send_load_machine(31, 32'hFFFF_FFF0);
        send_load_job(0, 32'd0, 16'hFFFF, 8'd2);
        send_load_job(63, 32'hFFFF_FF00, 16'h0100, 8'd255);
        send_load_job(1, 32'd100, 16'h0001, 8'd1);
        send_gene(0, 0, 16'hFFFF);
        send_gene(0, 31, 16'hFFFF);
        send_gene(0, 0, 16'd5);
        send_gene(63, 0, 16'd0);
        send_gene(1, 0, 16'd0);
        send_clear();
        send_load_job(2, 32'd7, 16'h0000, 8'd0);
        send_gene(2, 31, 16'd3);
        send_load_job(3, 32'd50, 16'h0080, 8'd1);
        send_load_machine(5, 32'd20);
        send_gene(3, 5, 16'd1);
        send_load_machine(1, 32'hFFFF_FFFF);
        send_gene(63, 1, 16'hFFFF);

        idling_on = 1'b0;
        send_load_machine(0, 32'hFFFF_FFFF);
        send_clear();

        for (int n = 0; n < 1750; n++)
        begin
            idling_on = (n < 700 || n >= 1100);
            pick = $urandom_range(0, 99);
            if (pick < 12)
                send_load_job($urandom_range(0, 63), random_time(), 16'($urandom),
                              random_count());
            else if (pick < 18)
                send_load_machine($urandom_range(0, 31), random_time());
            else if (pick < 20)
                send_clear();
            else
                send_gene(pick_job(pick < 28), pick_machine(), 16'($urandom));
        end
        start <= 1'b0;

        while (placements.expected_q.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (placements.errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule
